### rtl/core/whp_pkg.sv
// Shared types and constants of the window pair histogram core.
package whp_pkg;

    localparam int POS_W      = 28;
    localparam int MAX_WIN_W  = 22;
    localparam int CELLS      = 26;
    localparam int CELL_W     = 5;
    localparam int CLIP_BASE  = 2;
    localparam int CLIP_SLOTS = 8;

    localparam logic [1:0] OP_ADD    = 2'd0;
    localparam logic [1:0] OP_READ   = 2'd1;
    localparam logic [1:0] OP_CLEAR  = 2'd2;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    typedef enum logic [1:0] {
        CMD_ADD,
        CMD_READ,
        CMD_CLEAR
    } cmd_kind_t;

    // One classified transaction handed from the front to the back.
    // For a read, first_win holds the window to read.
    typedef struct packed {
        cmd_kind_t              kind;
        logic [MAX_WIN_W-1:0]   first_win;
        logic [MAX_WIN_W-1:0]   last_win;
        logic [CELLS-1:0]       inc_mask;
        logic [CELL_W-1:0]      cnt_sel;
        logic                   zero_value;
        logic                   out_range;
    } cmd_t;

    // Queue status seen by the front and the back.
    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

endpackage

### rtl/core/whp_front.sv
// Front part: accepts transactions, works out window runs and counter masks.
module whp_front #(
    parameter int WINDOW_LENGTH = 600,
    parameter int WINDOW_STEP   = 100,
    parameter int NUM_WINDOWS   = 4096
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [1:0]                  op,
    input  logic                        pair_valid,
    input  logic [5:0]                  pair_type,
    input  logic                        mei_on_first,
    input  logic [whp_pkg::POS_W-1:0]   left_pos,
    input  logic [whp_pkg::POS_W-1:0]   right_pos,
    input  logic [11:0]                 read_window,
    input  logic [1:0]                  read_category,
    input  logic [2:0]                  read_slot,
    input  logic                        hold,
    input  whp_pkg::queue_status_t      q_status,
    output logic                        push,
    output whp_pkg::cmd_t               push_cmd
);

    localparam int PW = whp_pkg::POS_W;
    localparam logic [PW:0] RECIP = (PW+1)'((64'd1 << PW) / WINDOW_STEP);
    localparam logic [15:0] STEP  = 16'(WINDOW_STEP);
    localparam logic [PW-1:0] LEN = PW'(WINDOW_LENGTH);
    localparam logic [31:0] LAST_WIN = 32'(NUM_WINDOWS - 1);

    typedef enum logic [2:0] {
        F_IDLE,
        F_MUL,
        F_CHK,
        F_FIX,
        F_RANGE,
        F_PUSH
    } fstate_t;

    fstate_t            state_reg;
    logic [PW-1:0]      x_reg;
    logic [PW-1:0]      min_reg;
    logic               neg_reg;
    logic               sel_reg;
    logic [2*PW:0]      prod_reg;
    logic [PW-1:0]      qe_reg;
    logic [PW+15:0]     back_reg;
    logic [PW:0]        q0_reg;
    logic [PW:0]        q1_reg;
    whp_pkg::cmd_t      cmd_reg;

    logic [PW+15:0]     rem;
    logic [PW:0]        q_fix;
    logic [31:0]        first32;
    logic [31:0]        last32;
    logic [whp_pkg::CELLS-1:0] mask;
    logic [whp_pkg::CELL_W-1:0] rd_cell;
    logic [2:0]         clip_slot;

    assign in_ready = (state_reg == F_IDLE) && !hold;
    assign push     = (state_reg == F_PUSH) && !q_status.full;
    assign push_cmd = cmd_reg;

    assign rem   = {16'b0, x_reg} - back_reg;
    assign q_fix = (rem >= (PW+16)'(STEP)) ? ({1'b0, qe_reg} + 1'b1) : {1'b0, qe_reg};

    always_comb
    begin
        if (neg_reg)
            first32 = (q0_reg == '0) ? 32'd1 : 32'd0;
        else
            first32 = 32'(q0_reg) + 32'd1;
        if (32'(q1_reg) > LAST_WIN)
            last32 = LAST_WIN;
        else
            last32 = 32'(q1_reg);
    end

    always_comb
    begin
        mask = '0;
        if (pair_type <= 6'd2)
        begin
            mask[(pair_type == 6'd0) ? 0 : 1] = 1'b1;
        end
        else
        begin
            for (int c = 1; c <= 3; c++)
            begin
                clip_slot = {mei_on_first, pair_type[2 + c], pair_type[2]};
                mask[whp_pkg::CLIP_BASE + (c - 1) * whp_pkg::CLIP_SLOTS + int'(clip_slot)] = 1'b1;
            end
        end
        clip_slot = '0;
    end

    always_comb
    begin
        if (read_category == 2'd0)
            rd_cell = whp_pkg::CELL_W'(read_slot[0]);
        else
            rd_cell = whp_pkg::CELL_W'(whp_pkg::CLIP_BASE)
                    + whp_pkg::CELL_W'({read_category - 2'd1, 3'b000})
                    + whp_pkg::CELL_W'(read_slot);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
        end
        else
        begin
            case (state_reg)
                F_IDLE:
                begin
                    if (in_valid && in_ready)
                    begin
                        cmd_reg.inc_mask   <= mask;
                        cmd_reg.cnt_sel    <= rd_cell;
                        cmd_reg.zero_value <= (read_category == 2'd0) && (read_slot >= 3'd2);
                        cmd_reg.out_range  <= 32'(read_window) > LAST_WIN;
                        cmd_reg.first_win  <= whp_pkg::MAX_WIN_W'(read_window);
                        cmd_reg.last_win   <= '0;
                        case (op)
                            whp_pkg::OP_ADD:
                            begin
                                cmd_reg.kind <= whp_pkg::CMD_ADD;
                                if (pair_valid)
                                begin
                                    neg_reg   <= right_pos < LEN;
                                    x_reg     <= (right_pos < LEN) ? (LEN - right_pos)
                                                                   : (right_pos - LEN);
                                    min_reg   <= left_pos;
                                    sel_reg   <= 1'b0;
                                    state_reg <= F_MUL;
                                end
                            end
                            whp_pkg::OP_READ:
                            begin
                                cmd_reg.kind <= whp_pkg::CMD_READ;
                                state_reg    <= F_PUSH;
                            end
                            whp_pkg::OP_CLEAR:
                            begin
                                cmd_reg.kind <= whp_pkg::CMD_CLEAR;
                                state_reg    <= F_PUSH;
                            end
                            default:
                            begin
                                state_reg <= F_IDLE;
                            end
                        endcase
                    end
                end
                F_MUL:
                begin
                    prod_reg  <= (2*PW+1)'({1'b0, x_reg}) * (2*PW+1)'(RECIP);
                    state_reg <= F_CHK;
                end
                F_CHK:
                begin
                    qe_reg    <= prod_reg[2*PW-1:PW];
                    back_reg  <= (PW+16)'(prod_reg[2*PW-1:PW]) * (PW+16)'(STEP);
                    state_reg <= F_FIX;
                end
                F_FIX:
                begin
                    if (!sel_reg)
                    begin
                        q0_reg    <= q_fix;
                        x_reg     <= min_reg;
                        sel_reg   <= 1'b1;
                        state_reg <= F_MUL;
                    end
                    else
                    begin
                        q1_reg    <= q_fix;
                        state_reg <= F_RANGE;
                    end
                end
                F_RANGE:
                begin
                    cmd_reg.first_win <= first32[whp_pkg::MAX_WIN_W-1:0];
                    cmd_reg.last_win  <= last32[whp_pkg::MAX_WIN_W-1:0];
                    state_reg <= (first32 > last32) ? F_IDLE : F_PUSH;
                end
                F_PUSH:
                begin
                    if (!q_status.full)
                        state_reg <= F_IDLE;
                end
                default:
                begin
                    state_reg <= F_IDLE;
                end
            endcase
        end
    end

endmodule

### rtl/core/whp_queue.sv
// Short command queue between the front and the back.
module whp_queue (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    wr,
    input  whp_pkg::cmd_t           wr_cmd,
    input  logic                    rd,
    output whp_pkg::cmd_t           rd_cmd,
    output whp_pkg::queue_status_t  status
);

    localparam int DEPTH = 4;
    localparam int AW    = $clog2(DEPTH);

    whp_pkg::cmd_t  slots_reg [DEPTH];
    logic [AW-1:0]  wp_reg;
    logic [AW-1:0]  rp_reg;
    logic [AW:0]    cnt_reg;

    assign status.full  = cnt_reg == (AW+1)'(DEPTH);
    assign status.empty = cnt_reg == '0;
    assign rd_cmd       = slots_reg[rp_reg];

    always_ff @(posedge clk)
    begin
        if (wr)
            slots_reg[wp_reg] <= wr_cmd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (wr)
                wp_reg <= wp_reg + 1'b1;
            if (rd)
                rp_reg <= rp_reg + 1'b1;
            cnt_reg <= cnt_reg + (AW+1)'(wr) - (AW+1)'(rd);
        end
    end

endmodule

### rtl/core/whp_back.sv
// Back part: walks window runs over the counter memory and answers reads.
module whp_back #(
    parameter int NUM_WINDOWS = 4096,
    parameter int COUNT_WIDTH = 32
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  whp_pkg::queue_status_t  q_status,
    input  whp_pkg::cmd_t           cmd,
    output logic                    pop,
    output logic                    clearing,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic [31:0]             count_value,
    output logic                    window_touched
);

    localparam int WIN_W = (NUM_WINDOWS > 1) ? $clog2(NUM_WINDOWS) : 1;
    localparam int ROW_W = whp_pkg::CELLS * COUNT_WIDTH + 1;
    localparam logic [WIN_W-1:0] LAST_ADDR = WIN_W'(NUM_WINDOWS - 1);

    typedef enum logic [2:0] {
        B_CLEAR,
        B_IDLE,
        B_RD,
        B_WR,
        B_RSP
    } bstate_t;

    bstate_t            state_reg;
    whp_pkg::cmd_t      cmd_reg;
    logic [WIN_W-1:0]   w_reg;
    logic [ROW_W-1:0]   rd_data_reg;
    logic               out_valid_reg;
    logic [31:0]        count_reg;
    logic               touched_reg;

    logic [ROW_W-1:0]   rows [NUM_WINDOWS];

    logic               mem_we;
    logic [WIN_W-1:0]   mem_waddr;
    logic [ROW_W-1:0]   mem_wdata;
    logic               mem_re;
    logic [ROW_W-1:0]   bumped;
    logic [COUNT_WIDTH-1:0] sel_count;
    logic               out_free;
    logic               rsp_load;

    assign pop            = (state_reg == B_IDLE) && !q_status.empty;
    assign clearing       = state_reg == B_CLEAR;
    assign out_valid      = out_valid_reg;
    assign count_value    = count_reg;
    assign window_touched = touched_reg;
    assign out_free       = !out_valid_reg || out_ready;
    assign rsp_load       = (state_reg == B_RSP) && out_free;
    assign mem_re         = state_reg == B_RD;
    assign mem_we         = (state_reg == B_WR) || (state_reg == B_CLEAR);
    assign mem_waddr      = w_reg;
    assign mem_wdata      = (state_reg == B_CLEAR) ? '0 : bumped;
    assign sel_count      = rd_data_reg[cmd_reg.cnt_sel * COUNT_WIDTH +: COUNT_WIDTH];

    // Saturating increment of every counter chosen by the mask.
    always_comb
    begin
        bumped = rd_data_reg;
        bumped[ROW_W-1] = 1'b1;
        for (int i = 0; i < whp_pkg::CELLS; i++)
        begin
            if (cmd_reg.inc_mask[i] && !(&rd_data_reg[i*COUNT_WIDTH +: COUNT_WIDTH]))
                bumped[i*COUNT_WIDTH +: COUNT_WIDTH] =
                    rd_data_reg[i*COUNT_WIDTH +: COUNT_WIDTH] + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            rows[mem_waddr] <= mem_wdata;
        if (mem_re)
            rd_data_reg <= rows[w_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_CLEAR;
            w_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            // A new answer loaded in the same cycle takes precedence over the drop.
            if (out_valid_reg && out_ready && !rsp_load)
                out_valid_reg <= 1'b0;
            case (state_reg)
                B_CLEAR:
                begin
                    if (w_reg == LAST_ADDR)
                        state_reg <= B_IDLE;
                    else
                        w_reg <= w_reg + 1'b1;
                end
                B_IDLE:
                begin
                    if (!q_status.empty)
                    begin
                        cmd_reg <= cmd;
                        w_reg   <= cmd.first_win[WIN_W-1:0];
                        case (cmd.kind)
                            whp_pkg::CMD_ADD:   state_reg <= B_RD;
                            whp_pkg::CMD_READ:  state_reg <= cmd.out_range ? B_RSP : B_RD;
                            whp_pkg::CMD_CLEAR:
                            begin
                                w_reg     <= '0;
                                state_reg <= B_CLEAR;
                            end
                            default:            state_reg <= B_IDLE;
                        endcase
                    end
                end
                B_RD:
                begin
                    state_reg <= (cmd_reg.kind == whp_pkg::CMD_ADD) ? B_WR : B_RSP;
                end
                B_WR:
                begin
                    if (w_reg == cmd_reg.last_win[WIN_W-1:0])
                        state_reg <= B_IDLE;
                    else
                    begin
                        w_reg     <= w_reg + 1'b1;
                        state_reg <= B_RD;
                    end
                end
                B_RSP:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        if (cmd_reg.out_range)
                        begin
                            count_reg   <= '0;
                            touched_reg <= 1'b0;
                        end
                        else
                        begin
                            count_reg   <= cmd_reg.zero_value ? 32'd0 : 32'(sel_count);
                            touched_reg <= rd_data_reg[ROW_W-1];
                        end
                        state_reg <= B_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= B_IDLE;
                end
            endcase
        end
    end

    a_no_pop_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == B_CLEAR) |-> !pop)
        else $error("command taken during clearing pass");

    a_walk_in_run: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == B_WR) |-> (w_reg <= cmd_reg.last_win[WIN_W-1:0]))
        else $error("window walk ran past the end of its run");

    a_rsp_loads_output: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_load |=> out_valid_reg)
        else $error("read answer was not presented");

endmodule

### rtl/core/window_pair_histogram_core.sv
// Top level of the window pair histogram core: front, command queue and back.
//
//  channel  | direction | handshake                   | payload
//  s_axis   | in        | s_axis_tvalid/s_axis_tready | tdata: pair fields, tuser: op
//  m_axis   | out       | m_axis_tvalid/m_axis_tready | tdata: count_value, window_touched
//
// A read passes from the front's command register through the queue, the back's command
// register and (in range) the row read into the output register. A valid add holds the
// front while the two constant divisions are done one after the other on its shared
// multiplier and the run is range checked (an empty run is dropped there); the back then
// takes the command and does a read-modify-write of a counter row per window, a read state
// then a write state. After reset, and after each clear transaction, the back sweeps
// NUM_WINDOWS rows, one a cycle, and takes no input meanwhile. The command queue holds four
// transactions, so the front accepts until it is full while the back walks a run or waits on an answer.
module window_pair_histogram_core #(
    parameter int WINDOW_LENGTH = 600,
    parameter int WINDOW_STEP   = 100,
    parameter int NUM_WINDOWS   = 4096,
    parameter int COUNT_WIDTH   = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // pair_valid, pair_type[5:0], mei_on_first, min_position[27:0],
    // max_position[27:0], read_window[11:0], read_category[1:0], read_slot[2:0], zeros
    input  logic [87:0] s_axis_tdata,
    // op[1:0]
    input  logic [1:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // count_value[31:0], window_touched, zeros
    output logic [39:0] m_axis_tdata
);

    whp_pkg::queue_status_t q_status;
    whp_pkg::cmd_t          push_cmd;
    whp_pkg::cmd_t          head_cmd;
    logic                   push;
    logic                   pop;
    logic                   clearing;
    logic [31:0]            count_value;
    logic                   window_touched;

    // The front is held off while the back sweeps the memory clear.
    whp_front #(
        .WINDOW_LENGTH (WINDOW_LENGTH),
        .WINDOW_STEP   (WINDOW_STEP),
        .NUM_WINDOWS   (NUM_WINDOWS)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (s_axis_tvalid),
        .in_ready     (s_axis_tready),
        .op           (s_axis_tuser),
        .pair_valid   (s_axis_tdata[0]),
        .pair_type    (s_axis_tdata[6:1]),
        .mei_on_first (s_axis_tdata[7]),
        .left_pos     (s_axis_tdata[35:8]),
        .right_pos    (s_axis_tdata[63:36]),
        .read_window  (s_axis_tdata[75:64]),
        .read_category(s_axis_tdata[77:76]),
        .read_slot    (s_axis_tdata[80:78]),
        .hold         (clearing),
        .q_status     (q_status),
        .push         (push),
        .push_cmd     (push_cmd)
    );

    whp_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr     (push),
        .wr_cmd (push_cmd),
        .rd     (pop),
        .rd_cmd (head_cmd),
        .status (q_status)
    );

    whp_back #(
        .NUM_WINDOWS (NUM_WINDOWS),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .q_status       (q_status),
        .cmd            (head_cmd),
        .pop            (pop),
        .clearing       (clearing),
        .out_valid      (m_axis_tvalid),
        .out_ready      (m_axis_tready),
        .count_value    (count_value),
        .window_touched (window_touched)
    );

    assign m_axis_tdata = {7'b0, window_touched, count_value};

endmodule
